[src/bpe_pkg.sv]
// Shared types and constants of the bit-plane payload extractor.
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [23:0] COOKIE_TXT  = 24'h545854;
	localparam logic [23:0] COOKIE_IMG  = 24'h494D47;
	localparam logic [4:0]  COOKIE_BITS = 5'd24;
	localparam logic [4:0]  BYTE_BITS   = 5'd8;

	localparam logic [20:0] MAX_CARRIER_PIXELS = 21'd1048576;
	localparam logic [12:0] MAX_TEXT_CHARS     = 13'd4096;

	localparam logic MODE_TEXT  = 1'b0;
	localparam logic MODE_IMAGE = 1'b1;

	localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
	localparam logic [2:0] KIND_HEIGHT    = 3'd1;
	localparam logic [2:0] KIND_WIDTH     = 3'd2;
	localparam logic [2:0] KIND_BADCOOKIE = 3'd3;
	localparam logic [2:0] KIND_TOOLARGE  = 3'd4;
	localparam logic [2:0] KIND_ENDED     = 3'd5;

	localparam logic [2:0] CFG_BIT_PLANE      = 3'd0;
	localparam logic [2:0] CFG_PAYLOAD_MODE   = 3'd1;
	localparam logic [2:0] CFG_MAX_CHARS      = 3'd2;
	localparam logic [2:0] CFG_CARRIER_PIXELS = 3'd3;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic       last_pixel;
	} in_word_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [2:0] item_kind;
		logic       end_of_run;
	} out_word_t;

	typedef struct packed {
		logic plane_bit;
		logic last;
	} bit_evt_t;

	typedef struct packed {
		logic [2:0]  bit_plane;
		logic        payload_mode;
		logic [12:0] max_chars;
		logic [20:0] carrier_pixels;
	} cfg_t;

	typedef enum logic [5:0] {
		PH_COOKIE  = 6'b000001,
		PH_TEXT    = 6'b000010,
		PH_HEIGHT  = 6'b000100,
		PH_WIDTH   = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_DONE    = 6'b100000
	} phase_t;

endpackage

`default_nettype wire

[src/bitplane_payload_extractor.sv]
// Top level of the bit-plane payload extractor: configuration registers and the three stages.
//
//   Channel   Handshake            Payload
//   input     push / full          in_word   (pixel_value, last_pixel)
//   result    pop / empty          out_word  (byte_value, item_kind, end_of_run)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel word is taken per cycle while full is low; results pass the queue and a register.
// The byte engine consumes one queued bit per cycle while its result word is empty or popped.
// While a result word waits unpopped, bits collect in the four-entry queue and full then rises.
// Reset clears the queue, the engine state and the valid flag, and loads the register defaults.
// Configuration writes are always taken at once.
`timescale 1ns / 1ps
`default_nettype none

module bitplane_payload_extractor (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	output logic                    full,
	input  wire bpe_pkg::in_word_t  in_word,
	output logic                    empty,
	input  wire                     pop,
	output bpe_pkg::out_word_t      out_word,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire [2:0]               cfg_index,
	input  wire [20:0]              cfg_data
);

	bpe_pkg::cfg_t     cfg_q;
	bpe_pkg::bit_evt_t front_evt;
	bpe_pkg::bit_evt_t queue_evt;
	logic              queue_empty;
	logic              evt_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_plane      <= 3'd0;
			cfg_q.payload_mode   <= bpe_pkg::MODE_TEXT;
			cfg_q.max_chars      <= bpe_pkg::MAX_TEXT_CHARS;
			cfg_q.carrier_pixels <= 21'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bpe_pkg::CFG_BIT_PLANE:      cfg_q.bit_plane      <= cfg_data[2:0];
				bpe_pkg::CFG_PAYLOAD_MODE:   cfg_q.payload_mode   <= cfg_data[0];
				bpe_pkg::CFG_MAX_CHARS:      cfg_q.max_chars      <= cfg_data[12:0];
				bpe_pkg::CFG_CARRIER_PIXELS: cfg_q.carrier_pixels <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bpe_front u_front (
		.in_word (in_word),
		.cfg     (cfg_q),
		.evt     (front_evt)
	);

	bpe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_evt),
		.full    (full),
		.rd_en   (evt_take),
		.rd_data (queue_evt),
		.empty   (queue_empty)
	);

	bpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.evt       (queue_evt),
		.evt_valid (!queue_empty),
		.evt_take  (evt_take),
		.out_word  (out_word),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

[src/bpe_front.sv]
// Front end: picks the carrier bit out of each pixel word and tags the last pixel.
`timescale 1ns / 1ps
`default_nettype none

module bpe_front (
	input  wire bpe_pkg::in_word_t in_word,
	input  wire bpe_pkg::cfg_t     cfg,
	output bpe_pkg::bit_evt_t      evt
);

	always_comb begin
		evt.plane_bit = in_word.pixel_value[cfg.bit_plane];
		evt.last      = in_word.last_pixel;
	end

endmodule

`default_nettype wire

[src/bpe_queue.sv]
// Short queue of extracted bits between the front end and the byte engine.
`timescale 1ns / 1ps
`default_nettype none

module bpe_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                wr_en,
	input  wire bpe_pkg::bit_evt_t wr_data,
	output logic               full,
	input  wire                rd_en,
	output bpe_pkg::bit_evt_t  rd_data,
	output logic               empty
);

	localparam int unsigned AW = bpe_pkg::QUEUE_AW;

	bpe_pkg::bit_evt_t mem_q [bpe_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == (AW+1)'(bpe_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

[src/bpe_back.sv]
// Back end: assembles bytes, checks the cookie and header, and holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module bpe_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire bpe_pkg::cfg_t     cfg,
	input  wire bpe_pkg::bit_evt_t evt,
	input  wire                    evt_valid,
	output logic                   evt_take,
	output bpe_pkg::out_word_t     out_word,
	output logic                   empty,
	input  wire                    pop
);

	bpe_pkg::phase_t phase_q;
	bpe_pkg::phase_t phase_d;
	logic [4:0]  bit_count_q;
	logic [4:0]  bit_count_d;
	logic [7:0]  shift_q;
	logic [7:0]  shift_d;
	logic [7:0]  height_q;
	logic [7:0]  height_d;
	logic [15:0] left_q;
	logic [15:0] left_d;
	logic        out_valid_q;
	bpe_pkg::out_word_t out_word_q;

	logic [7:0]  sh;
	logic [4:0]  bc;
	logic [23:0] cookie;
	logic [4:0]  cookie_idx;
	logic [12:0] lim;
	logic [20:0] cap;
	logic [15:0] size;
	logic [16:0] size_plus;
	logic [19:0] need;
	logic        too_large;
	logic        byte_done;
	logic        have;
	logic        eor;
	logic [7:0]  res_byte;
	logic [2:0]  res_kind;
	logic        res_valid;

	always_comb begin
		sh         = {shift_q[6:0], evt.plane_bit};
		bc         = bit_count_q + 5'd1;
		cookie     = (cfg.payload_mode == bpe_pkg::MODE_IMAGE) ?
			bpe_pkg::COOKIE_IMG : bpe_pkg::COOKIE_TXT;
		cookie_idx = bpe_pkg::COOKIE_BITS - bc;
		if (cfg.max_chars == '0) begin
			lim = 13'd1;
		end else if (cfg.max_chars > bpe_pkg::MAX_TEXT_CHARS) begin
			lim = bpe_pkg::MAX_TEXT_CHARS;
		end else begin
			lim = cfg.max_chars;
		end
		cap = (cfg.carrier_pixels > bpe_pkg::MAX_CARRIER_PIXELS) ?
			bpe_pkg::MAX_CARRIER_PIXELS : cfg.carrier_pixels;
		size      = {8'd0, height_q} * {8'd0, sh};
		size_plus = {1'b0, size} + 17'd5;
		need      = {size_plus, 3'b000};
		too_large = ({1'b0, need} > cap);
		byte_done = (bc == bpe_pkg::BYTE_BITS);

		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		height_d    = height_q;
		left_d      = left_q;
		have        = 1'b0;
		eor         = 1'b0;
		res_byte    = sh;
		res_kind    = bpe_pkg::KIND_PAYLOAD;
		res_valid   = 1'b0;

		if (phase_q != bpe_pkg::PH_DONE) begin
			shift_d     = sh;
			bit_count_d = bc;
			if (phase_q != bpe_pkg::PH_COOKIE && byte_done) begin
				shift_d     = '0;
				bit_count_d = '0;
				have        = 1'b1;
			end
		end

		unique case (phase_q)
			bpe_pkg::PH_COOKIE: begin
				if (evt.plane_bit != cookie[cookie_idx]) begin
					have     = 1'b1;
					eor      = 1'b1;
					res_kind = bpe_pkg::KIND_BADCOOKIE;
					phase_d  = bpe_pkg::PH_DONE;
				end else if (bc == bpe_pkg::COOKIE_BITS) begin
					shift_d     = '0;
					bit_count_d = '0;
					if (cfg.payload_mode == bpe_pkg::MODE_IMAGE) begin
						phase_d = bpe_pkg::PH_HEIGHT;
					end else begin
						phase_d = bpe_pkg::PH_TEXT;
						left_d  = {3'd0, lim};
					end
				end
			end
			bpe_pkg::PH_TEXT: begin
				if (have) begin
					if (sh == '0 || left_q < 16'd2) begin
						eor     = 1'b1;
						left_d  = '0;
						phase_d = bpe_pkg::PH_DONE;
					end else begin
						left_d = left_q - 16'd1;
					end
				end
			end
			bpe_pkg::PH_HEIGHT: begin
				if (have) begin
					height_d = sh;
					res_kind = bpe_pkg::KIND_HEIGHT;
					phase_d  = bpe_pkg::PH_WIDTH;
				end
			end
			bpe_pkg::PH_WIDTH: begin
				if (have) begin
					if (too_large) begin
						res_kind = bpe_pkg::KIND_TOOLARGE;
						eor      = 1'b1;
						phase_d  = bpe_pkg::PH_DONE;
					end else begin
						res_kind = bpe_pkg::KIND_WIDTH;
						left_d   = size;
						if (size == '0) begin
							eor     = 1'b1;
							phase_d = bpe_pkg::PH_DONE;
						end else begin
							phase_d = bpe_pkg::PH_PAYLOAD;
						end
					end
				end
			end
			bpe_pkg::PH_PAYLOAD: begin
				if (have) begin
					if (left_q < 16'd2) begin
						eor     = 1'b1;
						left_d  = '0;
						phase_d = bpe_pkg::PH_DONE;
					end else begin
						left_d = left_q - 16'd1;
					end
				end
			end
			bpe_pkg::PH_DONE: begin
				have = 1'b0;
			end
			default: begin
				phase_d = bpe_pkg::PH_DONE;
			end
		endcase

		if (phase_q == bpe_pkg::PH_DONE) begin
			res_valid = 1'b0;
		end else if (evt.last) begin
			res_valid = 1'b1;
			if (!(have && eor)) begin
				res_byte = sh;
				res_kind = bpe_pkg::KIND_ENDED;
			end
			eor = 1'b1;
		end else begin
			res_valid = have;
		end

		// The last pixel of a carrier always rearms the engine.
		if (evt.last) begin
			phase_d     = bpe_pkg::PH_COOKIE;
			bit_count_d = '0;
			shift_d     = '0;
			height_d    = '0;
			left_d      = '0;
		end
	end

	assign evt_take = evt_valid && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign out_word = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= bpe_pkg::PH_COOKIE;
			bit_count_q <= '0;
			shift_q     <= '0;
			height_q    <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt_take) begin
				phase_q     <= phase_d;
				bit_count_q <= bit_count_d;
				shift_q     <= shift_d;
				height_q    <= height_d;
				left_q      <= left_d;
			end
			if (evt_take && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take && res_valid) begin
			out_word_q.byte_value <= res_byte;
			out_word_q.item_kind  <= res_kind;
			out_word_q.end_of_run <= eor;
		end
	end

endmodule

`default_nettype wire
